FILE: design/fqsm_pkg.sv
// shared types and constants of the flow qos statistics monitor
`timescale 1ns / 1ps

package fqsm_pkg;

    // field widths of the stream items
    localparam int CMD_W    = 3;
    localparam int STAMP_W  = 48;
    localparam int BYTES_W  = 16;
    localparam int TOTAL_W  = 32;
    localparam int SPAN_W   = 49;
    localparam int JITTER_W = 48;
    localparam int DELAY_W  = 64;

    // packed stream widths, rounded up to whole bytes
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 456;
    localparam int OUT_PAD_W  = 7;

    // event codes carried in tuser
    typedef enum logic [CMD_W-1:0] {
        CMD_TX          = 3'd0,
        CMD_RX          = 3'd1,
        CMD_LOAD_DROP   = 3'd2,
        CMD_METER_DROP  = 3'd3,
        CMD_QUEUE_DROP  = 3'd4,
        CMD_CLEAR       = 3'd5
    } t_cmd;

    // one accepted input item
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [STAMP_W-1:0] now;
        logic [BYTES_W-1:0] byte_count;
        logic [STAMP_W-1:0] send_time;
    } t_in_item;

    // decoded event strobes
    typedef struct packed {
        logic tx;
        logic rx;
        logic load_drop;
        logic meter_drop;
        logic queue_drop;
        logic clear;
    } t_event;

    // one result item
    typedef struct packed {
        logic [TOTAL_W-1:0]  tx_sequence;
        logic [TOTAL_W-1:0]  tx_packet_total;
        logic [TOTAL_W-1:0]  tx_byte_total;
        logic [TOTAL_W-1:0]  rx_packet_total;
        logic [TOTAL_W-1:0]  rx_byte_total;
        logic [TOTAL_W-1:0]  lost_packets;
        logic [SPAN_W-1:0]   active_span;
        logic [JITTER_W-1:0] jitter_estimate;
        logic [DELAY_W-1:0]  delay_total;
        logic [TOTAL_W-1:0]  load_drop_total;
        logic [TOTAL_W-1:0]  meter_drop_total;
        logic [TOTAL_W-1:0]  queue_drop_total;
    } t_result;

endpackage

FILE: design/fqsm_jitter.sv
// interarrival jitter update: transit time and smoothed |D| filter
`timescale 1ns / 1ps

module fqsm_jitter #(
    parameter int TIME_BITS = 48
) (
    input  logic [TIME_BITS-1:0]        i_now,
    input  logic [TIME_BITS-1:0]        i_stamp,
    input  logic signed [TIME_BITS:0]   i_prev_transit,
    input  logic [TIME_BITS-1:0]        i_jitter,
    output logic signed [TIME_BITS:0]   o_transit,
    output logic [TIME_BITS-1:0]        o_jitter
);

    logic signed [TIME_BITS+1:0] delta;
    logic [TIME_BITS+1:0]        mag;
    logic signed [TIME_BITS+2:0] gap;
    logic signed [TIME_BITS+2:0] step;
    logic signed [TIME_BITS+2:0] sum;

    // transit time of this packet: receive time minus sender stamp
    assign o_transit = $signed({1'b0, i_now}) - $signed({1'b0, i_stamp});

    // D is the change of transit time, then its magnitude
    assign delta = $signed({o_transit[TIME_BITS], o_transit})
                 - $signed({i_prev_transit[TIME_BITS], i_prev_transit});
    assign mag   = delta[TIME_BITS+1] ? $unsigned(-delta) : $unsigned(delta);

    // j += (|D| - j) >>> 4, floor rounding on both signs
    assign gap  = $signed({1'b0, mag}) - $signed({3'b000, i_jitter});
    assign step = gap >>> 4;
    assign sum  = $signed({3'b000, i_jitter}) + step;

    // saturate to the time width
    assign o_jitter = (sum[TIME_BITS+2:TIME_BITS] != 3'b000) ? '1 : sum[TIME_BITS-1:0];

endmodule

FILE: design/fqsm_stats.sv
// statistics state registers and the snapshot of one result item
`timescale 1ns / 1ps

module fqsm_stats #(
    parameter int TIME_BITS  = 48,
    parameter int COUNT_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  fqsm_pkg::t_event              i_event,
    input  logic [fqsm_pkg::STAMP_W-1:0]  i_now,
    input  logic [fqsm_pkg::BYTES_W-1:0]  i_byte_count,
    input  logic [fqsm_pkg::STAMP_W-1:0]  i_send_time,
    output fqsm_pkg::t_result             o_result
);

    logic [COUNT_BITS-1:0]        r_tx_pkts,  n_tx_pkts;
    logic [COUNT_BITS-1:0]        r_tx_bytes, n_tx_bytes;
    logic [COUNT_BITS-1:0]        r_rx_pkts,  n_rx_pkts;
    logic [COUNT_BITS-1:0]        r_rx_bytes, n_rx_bytes;
    logic [COUNT_BITS-1:0]        r_load,     n_load;
    logic [COUNT_BITS-1:0]        r_meter,    n_meter;
    logic [COUNT_BITS-1:0]        r_queue,    n_queue;
    logic [TIME_BITS-1:0]         r_first_tx, n_first_tx;
    logic [TIME_BITS-1:0]         r_last_rx,  n_last_rx;
    logic signed [TIME_BITS:0]    r_prev_transit, n_prev_transit;
    logic [TIME_BITS-1:0]         r_jitter,   n_jitter;
    logic [fqsm_pkg::DELAY_W-1:0] r_delay,    n_delay;

    logic [TIME_BITS-1:0]               now_t;
    logic [TIME_BITS-1:0]               stamp_t;
    logic [COUNT_BITS-1:0]              bytes_c;
    logic signed [TIME_BITS:0]          transit;
    logic signed [fqsm_pkg::DELAY_W-1:0] transit_ext;
    logic [TIME_BITS-1:0]               jitter_upd;
    logic [COUNT_BITS-1:0]              seq;
    logic [COUNT_BITS-1:0]              lost;
    logic [TIME_BITS:0]                 span;

    // bring the port fields to the internal widths
    assign now_t   = TIME_BITS'(i_now);
    assign stamp_t = TIME_BITS'(i_send_time);
    assign bytes_c = COUNT_BITS'(i_byte_count);

    fqsm_jitter #(
        .TIME_BITS (TIME_BITS)
    ) u_jitter (
        .i_now          (now_t),
        .i_stamp        (stamp_t),
        .i_prev_transit (r_prev_transit),
        .i_jitter       (r_jitter),
        .o_transit      (transit),
        .o_jitter       (jitter_upd)
    );

    assign transit_ext = 64'(transit);

    // next state for the event in the input register
    always_comb begin
        n_tx_pkts      = r_tx_pkts;
        n_tx_bytes     = r_tx_bytes;
        n_rx_pkts      = r_rx_pkts;
        n_rx_bytes     = r_rx_bytes;
        n_load         = r_load;
        n_meter        = r_meter;
        n_queue        = r_queue;
        n_first_tx     = r_first_tx;
        n_last_rx      = r_last_rx;
        n_prev_transit = r_prev_transit;
        n_jitter       = r_jitter;
        n_delay        = r_delay;
        seq            = '0;
        if (i_event.tx) begin
            n_tx_pkts  = r_tx_pkts + COUNT_BITS'(1);
            n_tx_bytes = r_tx_bytes + bytes_c;
            seq        = r_tx_pkts;
            if (n_tx_pkts == COUNT_BITS'(1)) begin
                n_first_tx = now_t;
            end
        end
        if (i_event.rx) begin
            n_rx_pkts      = r_rx_pkts + COUNT_BITS'(1);
            n_rx_bytes     = r_rx_bytes + bytes_c;
            n_jitter       = jitter_upd;
            n_last_rx      = now_t;
            n_prev_transit = transit;
            n_delay        = r_delay + $unsigned(transit_ext);
        end
        if (i_event.load_drop) begin
            n_load = r_load + COUNT_BITS'(1);
        end
        if (i_event.meter_drop) begin
            n_meter = r_meter + COUNT_BITS'(1);
        end
        if (i_event.queue_drop) begin
            n_queue = r_queue + COUNT_BITS'(1);
        end
        // clear takes the current time as the new origin
        if (i_event.clear) begin
            n_tx_pkts      = '0;
            n_tx_bytes     = '0;
            n_rx_pkts      = '0;
            n_rx_bytes     = '0;
            n_load         = '0;
            n_meter        = '0;
            n_queue        = '0;
            n_first_tx     = now_t;
            n_last_rx      = now_t;
            n_prev_transit = '0;
            n_jitter       = '0;
            n_delay        = '0;
        end
    end

    // derived figures from the updated state
    assign lost = (n_tx_pkts != '0 && n_tx_pkts >= n_rx_pkts) ? (n_tx_pkts - n_rx_pkts) : '0;
    assign span = (n_rx_pkts != '0) ? ({1'b0, n_last_rx} - {1'b0, n_first_tx}) : '0;

    // snapshot of the state after this item
    always_comb begin
        o_result.tx_sequence      = fqsm_pkg::TOTAL_W'(seq);
        o_result.tx_packet_total  = fqsm_pkg::TOTAL_W'(n_tx_pkts);
        o_result.tx_byte_total    = fqsm_pkg::TOTAL_W'(n_tx_bytes);
        o_result.rx_packet_total  = fqsm_pkg::TOTAL_W'(n_rx_pkts);
        o_result.rx_byte_total    = fqsm_pkg::TOTAL_W'(n_rx_bytes);
        o_result.lost_packets     = fqsm_pkg::TOTAL_W'(lost);
        o_result.active_span      = fqsm_pkg::SPAN_W'(span);
        o_result.jitter_estimate  = fqsm_pkg::JITTER_W'(n_jitter);
        o_result.delay_total      = n_delay;
        o_result.load_drop_total  = fqsm_pkg::TOTAL_W'(n_load);
        o_result.meter_drop_total = fqsm_pkg::TOTAL_W'(n_meter);
        o_result.queue_drop_total = fqsm_pkg::TOTAL_W'(n_queue);
    end

    // state registers advance once per processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_pkts      <= '0;
            r_tx_bytes     <= '0;
            r_rx_pkts      <= '0;
            r_rx_bytes     <= '0;
            r_load         <= '0;
            r_meter        <= '0;
            r_queue        <= '0;
            r_first_tx     <= '0;
            r_last_rx      <= '0;
            r_prev_transit <= '0;
            r_jitter       <= '0;
            r_delay        <= '0;
        end else if (i_fire) begin
            r_tx_pkts      <= n_tx_pkts;
            r_tx_bytes     <= n_tx_bytes;
            r_rx_pkts      <= n_rx_pkts;
            r_rx_bytes     <= n_rx_bytes;
            r_load         <= n_load;
            r_meter        <= n_meter;
            r_queue        <= n_queue;
            r_first_tx     <= n_first_tx;
            r_last_rx      <= n_last_rx;
            r_prev_transit <= n_prev_transit;
            r_jitter       <= n_jitter;
            r_delay        <= n_delay;
        end
    end

endmodule

FILE: design/flow_qos_statistics_monitor_core.sv
// top level of the flow qos statistics monitor: input and result registers
//
//  channel   | dir | tdata (low bit up)                          | tuser
//  ----------+-----+---------------------------------------------+------
//  s (event) | in  | now, byte_count, send_time, 112 bits         | cmd
//  m (stats) | out | tx_sequence .. queue_drop_total, 456 bits    | none
//
//  one item per cycle sustained while each result is taken; a taken item sits in
//  the input register, then the single update pass of the statistics registers
//  loads its result into the result register, which drives the result port
//  i_rst_n is synchronous and clears all counters, times and jitter to zero
//  when the result is not taken, the input register keeps one more item and
//  then tready drops until the result moves on
`timescale 1ns / 1ps

module flow_qos_statistics_monitor_core #(
    parameter int TIME_BITS  = 48,
    parameter int COUNT_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // now, byte_count, send_time
    input  logic [fqsm_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // cmd
    input  logic [fqsm_pkg::CMD_W-1:0]       i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // tx_sequence, tx_packet_total, tx_byte_total, rx_packet_total,
    // rx_byte_total, lost_packets, active_span, jitter_estimate,
    // delay_total, load_drop_total, meter_drop_total, queue_drop_total, zero pad
    output logic [fqsm_pkg::OUT_DATA_W-1:0]  o_m_tdata
);

    logic               r_in_valid;
    fqsm_pkg::t_in_item r_in;
    logic               r_out_valid;
    fqsm_pkg::t_result  r_out;

    logic               fire;
    fqsm_pkg::t_event   evt;
    fqsm_pkg::t_result  snapshot;

    // the held item is processed when the result register is free
    assign fire       = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || fire;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in.cmd        <= i_s_tuser;
            r_in.now        <= i_s_tdata[47:0];
            r_in.byte_count <= i_s_tdata[63:48];
            r_in.send_time  <= i_s_tdata[111:64];
        end
    end

    // event decode
    always_comb begin
        evt = '0;
        if (fire) begin
            case (fqsm_pkg::t_cmd'(r_in.cmd))
                fqsm_pkg::CMD_TX:         evt.tx         = 1'b1;
                fqsm_pkg::CMD_RX:         evt.rx         = 1'b1;
                fqsm_pkg::CMD_LOAD_DROP:  evt.load_drop  = 1'b1;
                fqsm_pkg::CMD_METER_DROP: evt.meter_drop = 1'b1;
                fqsm_pkg::CMD_QUEUE_DROP: evt.queue_drop = 1'b1;
                fqsm_pkg::CMD_CLEAR:      evt.clear      = 1'b1;
                default:                  evt            = '0;
            endcase
        end
    end

    fqsm_stats #(
        .TIME_BITS  (TIME_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_stats (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_event      (evt),
        .i_now        (r_in.now),
        .i_byte_count (r_in.byte_count),
        .i_send_time  (r_in.send_time),
        .o_result     (snapshot)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= snapshot;
        end
    end

    // pack the result, first field in the low bits
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {
        {fqsm_pkg::OUT_PAD_W{1'b0}},
        r_out.queue_drop_total,
        r_out.meter_drop_total,
        r_out.load_drop_total,
        r_out.delay_total,
        r_out.jitter_estimate,
        r_out.active_span,
        r_out.lost_packets,
        r_out.rx_byte_total,
        r_out.rx_packet_total,
        r_out.tx_byte_total,
        r_out.tx_packet_total,
        r_out.tx_sequence
    };

endmodule

FILE: design/fqsm_checker.sv
// port-level checks of the flow qos statistics monitor and their binding
`timescale 1ns / 1ps

module fqsm_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_s_tready,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [fqsm_pkg::OUT_DATA_W-1:0]  o_m_tdata
);

    // a stalled result keeps its valid and its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // with the result side empty the input side is never held off
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty result register");

    // no span is reported before any packet is received
    a_span_needs_rx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[127:96] == 32'd0 |-> o_m_tdata[240:192] == 49'd0)
        else $error("active span without received packets");

    // a transmit sequence number is one below the transmit count
    a_seq_follows_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[31:0] != 32'd0
        |-> o_m_tdata[31:0] + 32'd1 == o_m_tdata[63:32])
        else $error("sequence number does not match transmit count");

endmodule

bind flow_qos_statistics_monitor_core fqsm_checker u_fqsm_checker (.*);
